// ===== hdl/gli_pkg.sv =====
// Shared constants and types of the Gilbert loss injector.
`default_nettype none

package gli_pkg;

   localparam int TagW     = 8;
   localparam int ThrW     = 8;
   localparam int SeedW    = 31;
   localparam int CountW   = 16;
   localparam int DrawW    = 15;
   localparam int CsrDataW = 31;
   localparam int CsrIdxW  = 2;

   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [SeedW-1:0] LcgMult = SeedW'(32'd1103515245);
   localparam logic [SeedW-1:0] LcgIncr = SeedW'(32'd12345);
   localparam int LcgShift = 16;

   // floor(r / 100) == (r * 5243) >> 19 for every 15-bit r
   localparam int RecipShift = 19;
   localparam int RecipW     = DrawW + 13;
   localparam logic [RecipW-1:0] RecipMult = RecipW'(5243);
   localparam int QuotW = RecipW - RecipShift;
   localparam logic [DrawW-1:0] ModDiv = DrawW'(100);
   localparam int RemW = 7;

   localparam logic [ThrW-1:0] BurstWrapAt   = ThrW'(50);
   localparam logic [ThrW-1:0] BurstRestart  = ThrW'(2);
   localparam logic [ThrW-1:0] KeepFloor     = ThrW'(90);

   localparam logic [ThrW-1:0]   KeepReset   = ThrW'(98);
   localparam logic [ThrW-1:0]   BurstReset  = ThrW'(2);
   localparam logic [SeedW-1:0]  SeedReset   = SeedW'(1);
   localparam logic [CountW-1:0] PeriodReset = CountW'(1000);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEEP_INIT    = 2'd0,
      CSR_BURST_INIT   = 2'd1,
      CSR_SEED_INIT    = 2'd2,
      CSR_SWEEP_PERIOD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                en;
      csr_index_type       index;
      logic [CsrDataW-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [TagW-1:0]   tag;
      logic [DrawW-1:0]  draw;
      logic [ThrW-1:0]   keep;
      logic [ThrW-1:0]   burst;
      logic [CountW-1:0] count;
   } item_type;

endpackage

`default_nettype wire

// ===== hdl/gli_front.sv =====
// Front end: accepts packets, steps the sweep schedule and draws the random number.
`default_nettype none

module gli_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire gli_pkg::csr_write_type     csr,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [gli_pkg::TagW-1:0]   req_packet_tag,
   input  wire logic                       queue_full,
   output logic                            push,
   output gli_pkg::item_type               push_item
);

   logic [gli_pkg::SeedW-1:0]  seed_ff, seed_in;
   logic [gli_pkg::CountW-1:0] count_ff, count_in;
   logic [gli_pkg::CountW-1:0] period_ff, period_in;
   logic [gli_pkg::ThrW-1:0]   keep_ff, keep_in;
   logic [gli_pkg::ThrW-1:0]   burst_ff, burst_in;

   logic                       accept;
   logic                       sweep;
   logic                       burst_wrap;
   logic [gli_pkg::ThrW-1:0]   keep_dec;
   logic [gli_pkg::ThrW-1:0]   keep_now;
   logic [gli_pkg::ThrW-1:0]   burst_now;
   logic [gli_pkg::CountW-1:0] count_now;
   logic [gli_pkg::SeedW-1:0]  lcg_prod;
   logic [gli_pkg::SeedW-1:0]  lcg_sum;
   logic [gli_pkg::DrawW-1:0]  draw;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   always_comb begin
      sweep      = count_ff >= period_ff;
      burst_wrap = burst_ff >= gli_pkg::BurstWrapAt;
      keep_dec   = burst_wrap ? keep_ff - gli_pkg::ThrW'(1) : keep_ff;
      if (sweep) begin
         burst_now = burst_wrap ? gli_pkg::BurstRestart : burst_ff + gli_pkg::ThrW'(1);
         keep_now  = (keep_dec < gli_pkg::KeepFloor) ? gli_pkg::KeepFloor : keep_dec;
         count_now = gli_pkg::CountW'(1);
      end else begin
         burst_now = burst_ff;
         keep_now  = keep_ff;
         count_now = count_ff + gli_pkg::CountW'(1);
      end
      lcg_prod = seed_ff * gli_pkg::LcgMult;
      lcg_sum  = lcg_prod + gli_pkg::LcgIncr;
      draw     = lcg_sum[gli_pkg::LcgShift +: gli_pkg::DrawW];
   end

   always_comb begin
      push_item.tag   = req_packet_tag;
      push_item.draw  = draw;
      push_item.keep  = keep_now;
      push_item.burst = burst_now;
      push_item.count = count_now;
   end

   always_comb begin
      seed_in   = seed_ff;
      count_in  = count_ff;
      period_in = period_ff;
      keep_in   = keep_ff;
      burst_in  = burst_ff;
      if (accept) begin
         seed_in  = gli_pkg::SeedW'(draw);
         count_in = count_now;
         keep_in  = keep_now;
         burst_in = burst_now;
      end
      if (csr.en) begin
         case (csr.index)
            gli_pkg::CSR_KEEP_INIT:    keep_in   = csr.data[gli_pkg::ThrW-1:0];
            gli_pkg::CSR_BURST_INIT:   burst_in  = csr.data[gli_pkg::ThrW-1:0];
            gli_pkg::CSR_SEED_INIT:    seed_in   = csr.data[gli_pkg::SeedW-1:0];
            gli_pkg::CSR_SWEEP_PERIOD: period_in = csr.data[gli_pkg::CountW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= gli_pkg::SeedReset;
         count_ff  <= '0;
         period_ff <= gli_pkg::PeriodReset;
         keep_ff   <= gli_pkg::KeepReset;
         burst_ff  <= gli_pkg::BurstReset;
      end else begin
         seed_ff   <= seed_in;
         count_ff  <= count_in;
         period_ff <= period_in;
         keep_ff   <= keep_in;
         burst_ff  <= burst_in;
      end
   end

   a_seed_narrow: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr.en) |=> (seed_ff[gli_pkg::SeedW-1:gli_pkg::DrawW] == '0))
      else $error("seed wider than a draw after a packet");

   a_keep_clamped: assert property (@(posedge clock) disable iff (reset)
      (accept && sweep && !csr.en) |=> (keep_ff >= gli_pkg::KeepFloor))
      else $error("keep threshold below floor after sweep step");

endmodule

`default_nettype wire

// ===== hdl/gli_queue.sv =====
// Short queue of packets with their draws and thresholds between front and back end.
`default_nettype none

module gli_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gli_pkg::item_type push_item,
   input  wire logic              pop,
   output gli_pkg::item_type      head_item,
   output logic                   full,
   output logic                   empty
);

   gli_pkg::item_type                entry_ff [gli_pkg::QueueDepth];
   logic [gli_pkg::QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [gli_pkg::QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [gli_pkg::QueueCntW-1:0]    fill_ff, fill_in;

   assign full      = fill_ff == gli_pkg::QueueCntW'(gli_pkg::QueueDepth);
   assign empty     = fill_ff == '0;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + gli_pkg::QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + gli_pkg::QueuePtrW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + gli_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - gli_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/gli_back.sv =====
// Back end: runs the two-state channel and registers the verdict beat.
`default_nettype none

module gli_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gli_pkg::item_type             head_item,
   input  wire logic                          queue_empty,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_verdict_drop,
   output logic [gli_pkg::TagW-1:0]           rsp_tag_echo,
   output logic [gli_pkg::ThrW-1:0]           rsp_keep_threshold_now,
   output logic [gli_pkg::ThrW-1:0]           rsp_burst_threshold_now,
   output logic [gli_pkg::CountW-1:0]         rsp_packets_in_period
);

   logic                         channel_ff, channel_in;
   logic                         valid_ff, valid_in;
   logic                         drop_ff;
   gli_pkg::item_type            item_ff;

   logic [gli_pkg::RecipW-1:0]   recip_prod;
   logic [gli_pkg::QuotW-1:0]    quot;
   logic [gli_pkg::DrawW-1:0]    quot_times_div;
   logic [gli_pkg::DrawW-1:0]    rem_wide;
   logic [gli_pkg::ThrW-1:0]     rem;
   logic                         drop;

   assign pop = !queue_empty && (!valid_ff || rsp_ready);

   always_comb begin
      recip_prod     = gli_pkg::RecipW'(head_item.draw) * gli_pkg::RecipMult;
      quot           = recip_prod[gli_pkg::RecipW-1:gli_pkg::RecipShift];
      quot_times_div = gli_pkg::DrawW'(gli_pkg::DrawW'(quot) * gli_pkg::ModDiv);
      rem_wide       = head_item.draw - quot_times_div;
      rem            = gli_pkg::ThrW'(rem_wide[gli_pkg::RemW-1:0]);
      drop           = channel_ff ? (rem < head_item.burst) : (rem > head_item.keep);
      channel_in     = pop ? drop : channel_ff;
      valid_in       = pop || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         channel_ff <= channel_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         drop_ff <= drop;
         item_ff <= head_item;
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_verdict_drop        = drop_ff;
   assign rsp_tag_echo            = item_ff.tag;
   assign rsp_keep_threshold_now  = item_ff.keep;
   assign rsp_burst_threshold_now = item_ff.burst;
   assign rsp_packets_in_period   = item_ff.count;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      pop |-> (rem_wide < gli_pkg::ModDiv))
      else $error("modulo by reciprocal out of range");

   a_state_follows_drop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (channel_ff == drop_ff))
      else $error("channel state differs from last verdict");

endmodule

`default_nettype wire

// ===== hdl/gilbert_loss_injector_core.sv =====
// Top level of the Gilbert two-state packet loss injector.
// Path: an accepted packet is written into the queue, and when popped its verdict
// is registered in the back end. Throughput: one packet per cycle while the queue
// is not full; the seed feedback closes through one 31-bit constant multiply in
// the front end, the channel state in the back end.
// Reset: synchronous; loads k=98, d=2, seed=1, period=1000, clears the counter,
// sets the channel good and empties the queue.
`default_nettype none

module gilbert_loss_injector_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [gli_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [gli_pkg::CsrDataW-1:0]  csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [gli_pkg::TagW-1:0]      req_packet_tag,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_verdict_drop,
   output logic [gli_pkg::TagW-1:0]           rsp_tag_echo,
   output logic [gli_pkg::ThrW-1:0]           rsp_keep_threshold_now,
   output logic [gli_pkg::ThrW-1:0]           rsp_burst_threshold_now,
   output logic [gli_pkg::CountW-1:0]         rsp_packets_in_period
);

   gli_pkg::csr_write_type csr;
   gli_pkg::item_type      push_item;
   gli_pkg::item_type      head_item;
   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_empty;

   always_comb begin
      csr.en    = csr_wr_en;
      csr.index = gli_pkg::csr_index_type'(csr_index);
      csr.data  = csr_wr_data;
   end

   gli_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_packet_tag (req_packet_tag),
      .queue_full     (queue_full),
      .push           (push),
      .push_item      (push_item)
   );

   gli_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   gli_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .head_item               (head_item),
      .queue_empty             (queue_empty),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_verdict_drop        (rsp_verdict_drop),
      .rsp_tag_echo            (rsp_tag_echo),
      .rsp_keep_threshold_now  (rsp_keep_threshold_now),
      .rsp_burst_threshold_now (rsp_burst_threshold_now),
      .rsp_packets_in_period   (rsp_packets_in_period)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_gilbert_loss_injector_core.sv =====
// Self-checking testbench for the Gilbert loss injector core: directed corners, then random traffic.
`timescale 1ns / 1ps

module tb_gilbert_loss_injector_core;
   import gli_pkg::*;

   localparam int RandomPackets = 1850;
   localparam int StallLimit    = 5000;
   localparam int IdlePercent   = 37;
   localparam int PrintLimit    = 30;

   typedef struct packed {
      logic              drop;
      logic [TagW-1:0]   tag;
      logic [ThrW-1:0]   keep;
      logic [ThrW-1:0]   burst;
      logic [CountW-1:0] count;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   csr_index_type       csr_index = CSR_KEEP_INIT;
   logic [CsrDataW-1:0] csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [TagW-1:0]     req_packet_tag = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_verdict_drop;
   logic [TagW-1:0]     rsp_tag_echo;
   logic [ThrW-1:0]     rsp_keep_threshold_now;
   logic [ThrW-1:0]     rsp_burst_threshold_now;
   logic [CountW-1:0]   rsp_packets_in_period;

   logic              chan_bad;
   logic [SeedW-1:0]  lcg_seed;
   logic [CountW-1:0] period_count;
   logic [ThrW-1:0]   keep_thr;
   logic [ThrW-1:0]   burst_thr;
   logic [CountW-1:0] sweep_len;

   verdict_type verdict_queue[$];
   bit          steady = 1'b0;
   int          errors = 0;
   int          packets_sent = 0;
   int          verdicts_checked = 0;
   int          drops_seen = 0;
   int          sweep_steps = 0;
   int          stall_cycles = 0;

   gilbert_loss_injector_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_wr_en               (csr_wr_en),
      .csr_index               (csr_index),
      .csr_wr_data             (csr_wr_data),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_packet_tag          (req_packet_tag),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_verdict_drop        (rsp_verdict_drop),
      .rsp_tag_echo            (rsp_tag_echo),
      .rsp_keep_threshold_now  (rsp_keep_threshold_now),
      .rsp_burst_threshold_now (rsp_burst_threshold_now),
      .rsp_packets_in_period   (rsp_packets_in_period)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic verdict_type predict_verdict(input logic [TagW-1:0] tag);
      logic [31:0]      lcg_next;
      logic [DrawW-1:0] draw;
      int               rem;
      verdict_type      v;
      // step the thresholds once the period is used up
      if (period_count >= sweep_len) begin
         period_count = '0;
         sweep_steps++;
         if (burst_thr >= 8'd50) begin
            burst_thr = 8'd2;
            keep_thr  = keep_thr - 8'd1;
         end else begin
            burst_thr = burst_thr + 8'd1;
         end
         if (keep_thr < 8'd90) begin
            keep_thr = 8'd90;
         end
      end
      lcg_next     = {1'b0, lcg_seed} * 32'd1103515245 + 32'd12345;
      draw         = lcg_next[30:16];
      lcg_seed     = SeedW'(draw);
      period_count = period_count + 1'b1;
      rem          = int'(draw) % 100;
      if (!chan_bad) begin
         v.drop = (rem > int'(keep_thr));
      end else begin
         v.drop = (rem < int'(burst_thr));
      end
      chan_bad = v.drop;
      v.tag    = tag;
      v.keep   = keep_thr;
      v.burst  = burst_thr;
      v.count  = period_count;
      return v;
   endfunction

   task automatic send_packet(input logic [TagW-1:0] tag);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_packet_tag <= tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      verdict_queue.push_back(predict_verdict(tag));
      packets_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_KEEP_INIT: begin
            keep_thr = data[ThrW-1:0];
         end
         CSR_BURST_INIT: begin
            burst_thr = data[ThrW-1:0];
         end
         CSR_SEED_INIT: begin
            lcg_seed = data[SeedW-1:0];
         end
         CSR_SWEEP_PERIOD: begin
            sweep_len = data[CountW-1:0];
         end
         default: begin
         end
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // hold input idle until every verdict is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_queue.size() != 0) @(posedge clock);
   endtask

   task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         if (errors < PrintLimit) begin
            $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         end
         errors++;
      end
   endtask

   task automatic test_reset_defaults();
      send_packet(8'h00);
      send_packet(8'hFF);
      send_packet(8'h55);
      send_packet(8'hAA);
   endtask

   task automatic test_threshold_extremes();
      settle();
      write_reg(CSR_KEEP_INIT, 31'd0);
      write_reg(CSR_BURST_INIT, 31'd255);
      send_packet(8'h01);
      send_packet(8'h80);
      settle();
      write_reg(CSR_KEEP_INIT, 31'd255);
      write_reg(CSR_BURST_INIT, 31'd0);
      send_packet(8'h7F);
      send_packet(8'hFE);
   endtask

   task automatic test_seed_extremes();
      settle();
      write_reg(CSR_SEED_INIT, 31'h7FFF_FFFF);
      send_packet(8'h33);
      settle();
      write_reg(CSR_SEED_INIT, 31'd0);
      send_packet(8'hCC);
   endtask

   task automatic test_zero_period();
      settle();
      write_reg(CSR_KEEP_INIT, 31'd0);
      write_reg(CSR_BURST_INIT, 31'd60);
      write_reg(CSR_SWEEP_PERIOD, 31'd0);
      send_packet(8'h10);
      send_packet(8'h20);
      send_packet(8'h30);
      settle();
      write_reg(CSR_KEEP_INIT, 31'd89);
      write_reg(CSR_BURST_INIT, 31'd49);
      send_packet(8'h40);
      send_packet(8'h50);
      send_packet(8'h60);
   endtask

   task automatic test_period_lowered();
      settle();
      write_reg(CSR_SWEEP_PERIOD, 31'd1000);
      repeat (4) send_packet(TagW'($urandom));
      settle();
      write_reg(CSR_SWEEP_PERIOD, 31'd3);
      send_packet(8'h0F);
      send_packet(8'hF0);
   endtask

   task automatic test_random_traffic(input int target);
      int sent;
      int phase;
      int n;
      sent  = 0;
      phase = 0;
      while (sent < target) begin
         settle();
         steady = (phase == 2);
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(4))
               0: write_reg(CSR_KEEP_INIT, 31'd0);
               1: write_reg(CSR_KEEP_INIT, 31'd255);
               2: write_reg(CSR_KEEP_INIT, 31'd89);
               default: write_reg(CSR_KEEP_INIT, CsrDataW'($urandom_range(255)));
            endcase
         end
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(5))
               0: write_reg(CSR_BURST_INIT, 31'd0);
               1: write_reg(CSR_BURST_INIT, 31'd255);
               2: write_reg(CSR_BURST_INIT, 31'd49);
               3: write_reg(CSR_BURST_INIT, 31'd50);
               default: write_reg(CSR_BURST_INIT, CsrDataW'($urandom_range(60)));
            endcase
         end
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(3))
               0: write_reg(CSR_SEED_INIT, 31'd0);
               1: write_reg(CSR_SEED_INIT, 31'h7FFF_FFFF);
               default: write_reg(CSR_SEED_INIT, CsrDataW'($urandom));
            endcase
         end
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(5))
               0: write_reg(CSR_SWEEP_PERIOD, 31'd0);
               1: write_reg(CSR_SWEEP_PERIOD, 31'd65535);
               2: write_reg(CSR_SWEEP_PERIOD, 31'd1000);
               default: write_reg(CSR_SWEEP_PERIOD, CsrDataW'($urandom_range(1, 12)));
            endcase
         end
         n = $urandom_range(40, 160);
         repeat (n) send_packet(TagW'($urandom));
         sent += n;
         phase++;
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_queue.size() == 0) begin
            if (errors < PrintLimit) begin
               $display("t=%0t verdict beat with nothing outstanding, tag %0d",
                        $time, rsp_tag_echo);
            end
            errors++;
         end else begin
            want = verdict_queue.pop_front();
            verdicts_checked++;
            if (rsp_verdict_drop === 1'b1) begin
               drops_seen++;
            end
            flag_field("verdict_drop", 32'(want.drop), 32'(rsp_verdict_drop));
            flag_field("tag_echo", 32'(want.tag), 32'(rsp_tag_echo));
            flag_field("keep_threshold_now", 32'(want.keep), 32'(rsp_keep_threshold_now));
            flag_field("burst_threshold_now", 32'(want.burst), 32'(rsp_burst_threshold_now));
            flag_field("packets_in_period", 32'(want.count), 32'(rsp_packets_in_period));
         end
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      rsp_ready <= steady || ($urandom_range(99) >= IdlePercent);
   end

   initial begin
      @(negedge reset);
      while (stall_cycles < StallLimit) @(posedge clock);
      $display("t=%0t watchdog: no beat for %0d cycles", $time, StallLimit);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      chan_bad     = 1'b0;
      lcg_seed     = SeedReset;
      period_count = '0;
      keep_thr     = KeepReset;
      burst_thr    = BurstReset;
      sweep_len    = PeriodReset;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_threshold_extremes();
      test_seed_extremes();
      test_zero_period();
      test_period_lowered();
      test_random_traffic(RandomPackets);
      settle();
      repeat (4) @(posedge clock);
      $display("Sent %0d packets over directed corners and random config phases.", packets_sent);
      $display("Checked %0d verdicts: %0d drops, %0d threshold sweep steps, %0d errors.",
               verdicts_checked, drops_seen, sweep_steps, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
